// ===== hw/rtl/psqe_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_pkg
// Shared widths, codes and command/status types of the segment quad expander.
// ----------------------------------------------------------------------------
package psqe_pkg;

	localparam int FRACTION_BITS = 4;

	localparam int PT_W     = 16;             // point coordinate, pixels
	localparam int DIFF_W   = 17;             // end minus start
	localparam int UV_W     = 18;             // dx+dy, dx-dy
	localparam int MAG_W    = 17;             // multiplier operand
	localparam int M2_W     = 17;             // twice the margin
	localparam int PROD_W   = 2 * MAG_W;
	localparam int SOFT_W   = 10;
	localparam int SQN_W    = 62;             // radicand L2 * 2^28
	localparam int SQ_PAIRS = SQN_W / 2;
	localparam int ROOT_W   = SQ_PAIRS;
	localparam int REM_W    = 34;
	localparam int LEN_FRAC = 14;
	localparam int DIV_QW   = 17;             // quotient bits
	localparam int DEN_W    = ROOT_W + 1;
	localparam int DVD_W    = PROD_W + LEN_FRAC + 1;
	localparam int OFF_W    = DIV_QW + 1;
	localparam int VTX_W    = 21;
	localparam int SUM_VW   = ((PT_W + FRACTION_BITS) > VTX_W ?
	                           (PT_W + FRACTION_BITS) : VTX_W) + 1;
	localparam int CNT_W    = 5;
	localparam int CORNER_W = 3;

	localparam logic [SOFT_W-1:0]   SOFT_RESET  = 10'd16;
	localparam logic [CORNER_W-1:0] LAST_CORNER = 3'd5;

	typedef logic [1:0] mul_sel_t;
	localparam mul_sel_t MSEL_DX = 2'd0;
	localparam mul_sel_t MSEL_DY = 2'd1;
	localparam mul_sel_t MSEL_U  = 2'd2;
	localparam mul_sel_t MSEL_V  = 2'd3;

	typedef struct packed {
		logic                capture;
		logic                diff;
		logic                mul;
		mul_sel_t            msel;
		logic                acc;
		logic                sq_load;
		logic                sq_step;
		logic                div_load;
		logic                div_step;
		logic                store_u;
		logic                store_v;
		logic                emit;
		logic [CORNER_W-1:0] corner;
	} psqe_cmd_t;

	typedef struct packed {
		logic seg;
		logic out_free;
	} psqe_stat_t;

endpackage

// ===== hw/rtl/psqe_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_dp
// Datapath: point store, shared multiplier, bit-serial square root and
// divider, corner offset selection and the registered output item.
// ----------------------------------------------------------------------------
module psqe_dp import psqe_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  psqe_cmd_t                cmd,
	output psqe_stat_t               stat,
	input  logic [SOFT_W-1:0]        edge_soft,
	input  logic signed [PT_W-1:0]   point_x,
	input  logic signed [PT_W-1:0]   point_y,
	input  logic                     line_start,
	input  logic signed [PT_W-1:0]   line_radius,
	input  logic                     out_stall,
	output logic                     out_valid,
	output logic signed [VTX_W-1:0]  vertex_x,
	output logic signed [VTX_W-1:0]  vertex_y,
	output logic signed [PT_W-1:0]   start_x,
	output logic signed [PT_W-1:0]   start_y,
	output logic signed [PT_W-1:0]   end_x,
	output logic signed [PT_W-1:0]   end_y,
	output logic signed [PT_W-1:0]   vertex_radius,
	output logic [CORNER_W-1:0]      corner_index,
	output logic                     last_vertex
);

	localparam logic signed [SUM_VW-1:0] VMAX_S = SUM_VW'((2 ** (VTX_W - 1)) - 1);
	localparam logic signed [SUM_VW-1:0] VMIN_S = -VMAX_S - SUM_VW'(1);

	logic signed [PT_W-1:0]   prev_x_q, prev_y_q;
	logic                     have_prev_q;
	logic signed [PT_W-1:0]   ax_q, ay_q, px_q, py_q, r_q;
	logic signed [DIFF_W-1:0] dx_q, dy_q;
	logic signed [UV_W-1:0]   u_q, v_q;
	logic [M2_W-1:0]          m2_q;
	logic [PROD_W-1:0]        prod_q, acc_q;
	logic [SQN_W-1:0]         sqn_q;
	logic [REM_W-1:0]         srem_q;
	logic [ROOT_W-1:0]        root_q;
	logic [DEN_W-1:0]         drem_q;
	logic [DIV_QW-1:0]        dq_q;
	logic signed [OFF_W-1:0]  qu_q, qv_q;

	// difference stage
	logic signed [DIFF_W-1:0] dx_w, dy_w;
	logic                     zero_w;
	logic [PT_W-1:0]          rpos_w;

	always_comb begin
		dx_w   = DIFF_W'(px_q) - DIFF_W'(ax_q);
		dy_w   = DIFF_W'(py_q) - DIFF_W'(ay_q);
		zero_w = (dx_w == '0) && (dy_w == '0);
		if (zero_w) begin
			dx_w = DIFF_W'(1);
		end
		rpos_w = r_q[PT_W-1] ? '0 : r_q;
	end

	// shared multiplier
	logic signed [UV_W-1:0] msrc_w;
	logic [MAG_W-1:0]       ma_w, mb_w;

	always_comb begin
		case (cmd.msel)
			MSEL_DX: msrc_w = UV_W'(dx_q);
			MSEL_DY: msrc_w = UV_W'(dy_q);
			MSEL_U:  msrc_w = u_q;
			default: msrc_w = v_q;
		endcase
		ma_w = msrc_w[UV_W-1] ? MAG_W'(-msrc_w) : MAG_W'(msrc_w);
		mb_w = (cmd.msel == MSEL_DX || cmd.msel == MSEL_DY) ? ma_w : MAG_W'(m2_q);
	end

	// square root step
	logic [REM_W+1:0] srw_w, strial_w;
	logic             sge_w;
	logic [PROD_W-1:0] l2_w;

	always_comb begin
		l2_w     = acc_q + prod_q;
		srw_w    = {srem_q, sqn_q[SQN_W-1 -: 2]};
		strial_w = (REM_W+2)'({root_q, 2'b01});
		sge_w    = srw_w >= strial_w;
	end

	// divide step
	logic [DVD_W-1:0] dvd_w;
	logic [DEN_W:0]   dt_w, dden_w;
	logic             dge_w;

	always_comb begin
		dvd_w  = DVD_W'({prod_q, LEN_FRAC'(0)}) + DVD_W'(root_q);
		dt_w   = {drem_q, dq_q[DIV_QW-1]};
		dden_w = (DEN_W+1)'({root_q, 1'b0});
		dge_w  = dt_w >= dden_w;
	end

	// corner offsets
	logic signed [OFF_W-1:0]  offx_w, offy_w;
	logic signed [PT_W-1:0]   bx_w, by_w;
	logic signed [SUM_VW-1:0] sx_w, sy_w;
	logic signed [VTX_W-1:0]  vx_w, vy_w;

	always_comb begin
		case (cmd.corner)
			3'd0:    begin offx_w = -qu_q; offy_w = qv_q;  end
			3'd1,
			3'd4:    begin offx_w = -qv_q; offy_w = -qu_q; end
			3'd2,
			3'd3:    begin offx_w = qv_q;  offy_w = qu_q;  end
			default: begin offx_w = qu_q;  offy_w = -qv_q; end
		endcase
		if (cmd.corner == 3'd2 || cmd.corner == 3'd3 || cmd.corner == 3'd5) begin
			bx_w = px_q;
			by_w = py_q;
		end else begin
			bx_w = ax_q;
			by_w = ay_q;
		end
		sx_w = (SUM_VW'(bx_w) <<< FRACTION_BITS) + SUM_VW'(offx_w);
		sy_w = (SUM_VW'(by_w) <<< FRACTION_BITS) + SUM_VW'(offy_w);
		if (sx_w > VMAX_S)      vx_w = VTX_W'(VMAX_S);
		else if (sx_w < VMIN_S) vx_w = VTX_W'(VMIN_S);
		else                    vx_w = VTX_W'(sx_w);
		if (sy_w > VMAX_S)      vy_w = VTX_W'(VMAX_S);
		else if (sy_w < VMIN_S) vy_w = VTX_W'(VMIN_S);
		else                    vy_w = VTX_W'(sy_w);
	end

	assign stat.seg      = !line_start && have_prev_q;
	assign stat.out_free = !out_valid || !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_x_q    <= '0;
			prev_y_q    <= '0;
			have_prev_q <= 1'b0;
			out_valid   <= 1'b0;
		end else begin
			if (cmd.capture) begin
				prev_x_q    <= point_x;
				prev_y_q    <= point_y;
				have_prev_q <= 1'b1;
			end
			if (cmd.emit)
				out_valid <= 1'b1;
			else if (!out_stall)
				out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			ax_q <= prev_x_q;
			ay_q <= prev_y_q;
			px_q <= point_x;
			py_q <= point_y;
			r_q  <= line_radius;
		end
		if (cmd.diff) begin
			dx_q <= dx_w;
			dy_q <= dy_w;
			u_q  <= UV_W'(dx_w) + UV_W'(dy_w);
			v_q  <= UV_W'(dx_w) - UV_W'(dy_w);
			m2_q <= M2_W'({rpos_w, 1'b0}) + M2_W'(edge_soft)
			        + M2_W'(2 ** (FRACTION_BITS + 1));
		end
		if (cmd.acc)
			acc_q <= prod_q;
		if (cmd.mul)
			prod_q <= PROD_W'(ma_w) * PROD_W'(mb_w);
		if (cmd.sq_load) begin
			sqn_q  <= SQN_W'({l2_w, 28'b0});
			srem_q <= '0;
			root_q <= '0;
		end else if (cmd.sq_step) begin
			sqn_q  <= {sqn_q[SQN_W-3:0], 2'b00};
			srem_q <= sge_w ? REM_W'(srw_w - strial_w) : REM_W'(srw_w);
			root_q <= {root_q[ROOT_W-2:0], sge_w};
		end
		if (cmd.div_load) begin
			drem_q <= dvd_w[DVD_W-1 -: DEN_W];
			dq_q   <= dvd_w[DIV_QW-1:0];
		end else if (cmd.div_step) begin
			drem_q <= dge_w ? DEN_W'(dt_w - dden_w) : DEN_W'(dt_w);
			dq_q   <= {dq_q[DIV_QW-2:0], dge_w};
		end
		if (cmd.store_u)
			qu_q <= u_q[UV_W-1] ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		if (cmd.store_v)
			qv_q <= v_q[UV_W-1] ? -$signed({1'b0, dq_q}) : $signed({1'b0, dq_q});
		if (cmd.emit) begin
			vertex_x      <= vx_w;
			vertex_y      <= vy_w;
			start_x       <= ax_q;
			start_y       <= ay_q;
			end_x         <= px_q;
			end_y         <= py_q;
			vertex_radius <= r_q;
			corner_index  <= cmd.corner;
			last_vertex   <= (cmd.corner == LAST_CORNER);
		end
	end

endmodule

// ===== hw/rtl/psqe_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// psqe_ctrl
// Sequencer: steps the datapath through difference, length, two scaled
// offsets and six corner emissions.
// ----------------------------------------------------------------------------
module psqe_ctrl import psqe_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_stall,
	input  psqe_stat_t stat,
	output psqe_cmd_t  cmd
);

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_DIFF = 4'd1;
	localparam logic [3:0] S_SQX  = 4'd2;
	localparam logic [3:0] S_SQY  = 4'd3;
	localparam logic [3:0] S_SQL  = 4'd4;
	localparam logic [3:0] S_SQRT = 4'd5;
	localparam logic [3:0] S_MULU = 4'd6;
	localparam logic [3:0] S_DLDU = 4'd7;
	localparam logic [3:0] S_DIVU = 4'd8;
	localparam logic [3:0] S_MULV = 4'd9;
	localparam logic [3:0] S_DLDV = 4'd10;
	localparam logic [3:0] S_DIVV = 4'd11;
	localparam logic [3:0] S_STV  = 4'd12;
	localparam logic [3:0] S_EMIT = 4'd13;

	localparam logic [CNT_W-1:0] SQ_LAST  = CNT_W'(SQ_PAIRS - 1);
	localparam logic [CNT_W-1:0] DIV_LAST = CNT_W'(DIV_QW - 1);

	logic [3:0]       state_q, state_d;
	logic [CNT_W-1:0] cnt_q, cnt_d;

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cnt_d   = cnt_q;
		cmd     = '0;
		cmd.corner = cnt_q[CORNER_W-1:0];
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					if (stat.seg)
						state_d = S_DIFF;
				end
			end
			S_DIFF: begin
				cmd.diff = 1'b1;
				state_d  = S_SQX;
			end
			S_SQX: begin
				cmd.mul  = 1'b1;
				cmd.msel = MSEL_DX;
				state_d  = S_SQY;
			end
			S_SQY: begin
				cmd.acc  = 1'b1;
				cmd.mul  = 1'b1;
				cmd.msel = MSEL_DY;
				state_d  = S_SQL;
			end
			S_SQL: begin
				cmd.sq_load = 1'b1;
				cnt_d       = '0;
				state_d     = S_SQRT;
			end
			S_SQRT: begin
				cmd.sq_step = 1'b1;
				cnt_d       = cnt_q + 1'b1;
				if (cnt_q == SQ_LAST)
					state_d = S_MULU;
			end
			S_MULU: begin
				cmd.mul  = 1'b1;
				cmd.msel = MSEL_U;
				state_d  = S_DLDU;
			end
			S_DLDU: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIVU;
			end
			S_DIVU: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = S_MULV;
			end
			S_MULV: begin
				cmd.store_u = 1'b1;
				cmd.mul     = 1'b1;
				cmd.msel    = MSEL_V;
				state_d     = S_DLDV;
			end
			S_DLDV: begin
				cmd.div_load = 1'b1;
				cnt_d        = '0;
				state_d      = S_DIVV;
			end
			S_DIVV: begin
				cmd.div_step = 1'b1;
				cnt_d        = cnt_q + 1'b1;
				if (cnt_q == DIV_LAST)
					state_d = S_STV;
			end
			S_STV: begin
				cmd.store_v = 1'b1;
				cnt_d       = '0;
				state_d     = S_EMIT;
			end
			S_EMIT: begin
				if (stat.out_free) begin
					cmd.emit = 1'b1;
					cnt_d    = cnt_q + 1'b1;
					if (cnt_q[CORNER_W-1:0] == LAST_CORNER)
						state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	a_emit_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit |-> stat.out_free)
		else $error("item emitted over a waiting result");

	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.emit && cmd.corner == LAST_CORNER) |=> (state_q == S_IDLE))
		else $error("sequencer did not return to idle after last corner");

	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EMIT) |-> (cnt_q <= CNT_W'(LAST_CORNER)))
		else $error("corner counter out of range");

endmodule

// ===== hw/rtl/polyline_segment_quad_expander.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// polyline_segment_quad_expander
// Expands each polyline segment into a six-vertex quad (two triangles) whose
// half-size covers radius, half the soft edge and one pixel.
// ----------------------------------------------------------------------------
//
//  channel  | direction | handshake          | payload
//  ---------+-----------+--------------------+--------------------------------
//  in       | to block  | in_valid/in_stall  | point_x/y, line_start, radius
//  out      | from block| out_valid/out_stall| vertex_x/y, start/end, corner
//  apb      | to block  | psel/penable       | edge_softness at address 0
//
// A start point (or any point with no predecessor) is taken with in_stall low
// and gives no item. After a segment point is accepted, the length comes from a
// 31-step bit-serial square root, then each of the two offset magnitudes from
// a 17-step restoring divider. The six vertices then leave one per cycle while
// out_stall is low; out_stall holds them.
// in_stall stays high from segment accept until the sixth vertex is loaded.
// Reset clears the previous point, the sequencer and the output valid.
module polyline_segment_quad_expander import psqe_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	// configuration
	input  logic                    psel,
	input  logic                    penable,
	input  logic                    pwrite,
	input  logic [2:0]              paddr,
	input  logic [31:0]             pwdata,
	output logic [31:0]             prdata,
	output logic                    pready,
	// input items
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic signed [PT_W-1:0]  point_x,
	input  logic signed [PT_W-1:0]  point_y,
	input  logic                    line_start,
	input  logic signed [PT_W-1:0]  line_radius,
	// result items
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic signed [VTX_W-1:0] vertex_x,
	output logic signed [VTX_W-1:0] vertex_y,
	output logic signed [PT_W-1:0]  start_x,
	output logic signed [PT_W-1:0]  start_y,
	output logic signed [PT_W-1:0]  end_x,
	output logic signed [PT_W-1:0]  end_y,
	output logic signed [PT_W-1:0]  vertex_radius,
	output logic [CORNER_W-1:0]     corner_index,
	output logic                    last_vertex
);

	logic [SOFT_W-1:0] soft_q;
	psqe_cmd_t         cmd;
	psqe_stat_t        stat;

	// Register file: one register at addresses 0 to 3 (paddr[2] low); addresses
	// 4 to 7 drop writes and read as zero.
	assign pready = 1'b1;
	assign prdata = (!paddr[2]) ? 32'(soft_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			soft_q <= SOFT_RESET;
		end else if (psel && penable && pwrite && !paddr[2]) begin
			soft_q <= pwdata[SOFT_W-1:0];
		end
	end

	psqe_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.stat     (stat),
		.cmd      (cmd)
	);

	psqe_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.stat          (stat),
		.edge_soft     (soft_q),
		.point_x       (point_x),
		.point_y       (point_y),
		.line_start    (line_start),
		.line_radius   (line_radius),
		.out_stall     (out_stall),
		.out_valid     (out_valid),
		.vertex_x      (vertex_x),
		.vertex_y      (vertex_y),
		.start_x       (start_x),
		.start_y       (start_y),
		.end_x         (end_x),
		.end_y         (end_y),
		.vertex_radius (vertex_radius),
		.corner_index  (corner_index),
		.last_vertex   (last_vertex)
	);

endmodule
